// ===== rtl/dtj_pkg.sv =====
// ----------------------------------------------------------------------------
// dtj_pkg
// Shared sizes and codes for the deadline timer job table.
// ----------------------------------------------------------------------------
package dtj_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int MAX_FIRES = 32;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int FIRE_W = $clog2(MAX_FIRES + 1);

  localparam int ID_W   = 32;
  localparam int TIME_W = 48;
  localparam int IVAL_W = 32;
  localparam int RUNS_W = 32;

  typedef enum logic [1:0] {
    OP_ADD_REPEAT = 2'd0,
    OP_ADD_ONCE   = 2'd1,
    OP_REMOVE     = 2'd2,
    OP_TICK       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_ADDED    = 3'd0,
    K_FULL     = 3'd1,
    K_REMOVED  = 3'd2,
    K_NOTFOUND = 3'd3,
    K_FIRED    = 3'd4,
    K_DONE     = 3'd5
  } kind_t;

endpackage

// ===== rtl/deadline_timer_job_table.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_job_table
// Table of interval timer jobs held in a synchronous memory with one write and one read port.
// ----------------------------------------------------------------------------
// Add: the result goes through S_EMIT to the output register. Remove: one full
//   memory scan, then S_EMIT. Tick: one full memory scan per fired job, plus
//   the empty scan that ends it (no scan at the fire cap: the done item follows).
// One input item at a time; in_ready is high only when idle. Output stalls add delay.
// Reset (synchronous, rst high): all slots free, next id 1, no item pending.
module deadline_timer_job_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic [dtj_pkg::TIME_W-1:0]   first_time,
  input  logic [dtj_pkg::IVAL_W-1:0]   interval_secs,
  input  logic [dtj_pkg::ID_W-1:0]     target_id,
  input  logic [dtj_pkg::TIME_W-1:0]   now_time,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   kind,
  output logic [dtj_pkg::ID_W-1:0]     job_id,
  output logic [dtj_pkg::TIME_W-1:0]   due_time,
  output logic [dtj_pkg::RUNS_W-1:0]   run_count,
  output logic                         last
);

  localparam int N = dtj_pkg::NUM_SLOTS;

  typedef enum logic [1:0] {S_IDLE, S_RM_SCAN, S_TK_SCAN, S_EMIT} state_t;
  state_t state;

  // Slot memory: one write port, one registered read port.
  logic [dtj_pkg::ID_W-1:0]   mem_id   [N];
  logic [dtj_pkg::TIME_W-1:0] mem_due  [N];
  logic [dtj_pkg::IVAL_W-1:0] mem_ival [N];
  logic                       mem_rep  [N];
  logic [dtj_pkg::RUNS_W-1:0] mem_runs [N];

  logic [dtj_pkg::ID_W-1:0]   rd_id;
  logic [dtj_pkg::TIME_W-1:0] rd_due;
  logic [dtj_pkg::IVAL_W-1:0] rd_ival;
  logic                       rd_rep;
  logic [dtj_pkg::RUNS_W-1:0] rd_runs;

  logic                       we;
  logic [dtj_pkg::SLOT_W-1:0] wa;
  logic [dtj_pkg::ID_W-1:0]   wd_id;
  logic [dtj_pkg::TIME_W-1:0] wd_due;
  logic [dtj_pkg::IVAL_W-1:0] wd_ival;
  logic                       wd_rep;
  logic [dtj_pkg::RUNS_W-1:0] wd_runs;

  // Valid bits stay in flops so reset frees every slot at once.
  logic [N-1:0] valid;

  // Scan control
  logic [dtj_pkg::CNT_W-1:0]  scan_idx;
  logic                       rd_vld;
  logic [dtj_pkg::SLOT_W-1:0] rd_slot;

  // Latched operands
  logic [dtj_pkg::ID_W-1:0]   target;
  logic [dtj_pkg::TIME_W-1:0] now;
  logic [dtj_pkg::ID_W-1:0]   next_id;
  logic                       hit;
  logic [dtj_pkg::FIRE_W-1:0] nfire;

  // Best candidate of the current tick scan
  logic                       found;
  logic [dtj_pkg::SLOT_W-1:0] best_slot;
  logic [dtj_pkg::ID_W-1:0]   best_id;
  logic [dtj_pkg::TIME_W-1:0] best_due;
  logic [dtj_pkg::IVAL_W-1:0] best_ival;
  logic                       best_rep;
  logic [dtj_pkg::RUNS_W-1:0] best_runs;

  // Pending result waiting for the output register
  logic [2:0]                 res_kind;
  logic [dtj_pkg::ID_W-1:0]   res_id;
  logic [dtj_pkg::TIME_W-1:0] res_due;
  logic [dtj_pkg::RUNS_W-1:0] res_runs;
  logic                       res_last;
  logic                       res_fire;

  logic                       free_any;
  logic [dtj_pkg::SLOT_W-1:0] free_slot;
  logic                       take;
  logic                       out_free;
  logic                       emit_go;
  logic                       scan_end;
  logic [dtj_pkg::TIME_W:0]   due_sum;
  logic [dtj_pkg::TIME_W-1:0] due_adv;
  logic [dtj_pkg::RUNS_W-1:0] runs_inc;
  logic [dtj_pkg::ID_W-1:0]   id_inc;

  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign emit_go  = (state == S_EMIT) && out_free;
  assign scan_end = (scan_idx == dtj_pkg::CNT_W'(N)) && !rd_vld;

  // Lowest free slot
  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_any  = 1'b1;
        free_slot = dtj_pkg::SLOT_W'(i);
      end
    end
  end

  // Repeating job advance, saturating at the top of the time range
  assign due_sum  = {1'b0, best_due} + (dtj_pkg::TIME_W + 1)'(best_ival);
  assign due_adv  = due_sum[dtj_pkg::TIME_W] ? '1 : due_sum[dtj_pkg::TIME_W-1:0];
  assign runs_inc = (&best_runs) ? best_runs : best_runs + 1'b1;
  assign id_inc   = (next_id + 1'b1 == '0) ? dtj_pkg::ID_W'(1) : next_id + 1'b1;

  // Memory write: add stores a new job; a fire writes the updated job back.
  always_comb begin
    we      = 1'b0;
    wa      = free_slot;
    wd_id   = next_id;
    wd_due  = first_time;
    wd_ival = interval_secs;
    wd_rep  = (opcode == dtj_pkg::OP_ADD_REPEAT);
    wd_runs = '0;
    if (take && (opcode == dtj_pkg::OP_ADD_REPEAT || opcode == dtj_pkg::OP_ADD_ONCE)) begin
      we = free_any;
    end else if (emit_go && res_fire) begin
      we      = 1'b1;
      wa      = best_slot;
      wd_id   = best_id;
      wd_due  = due_adv;
      wd_ival = best_ival;
      wd_rep  = best_rep;
      wd_runs = runs_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_id[wa]   <= wd_id;
      mem_due[wa]  <= wd_due;
      mem_ival[wa] <= wd_ival;
      mem_rep[wa]  <= wd_rep;
      mem_runs[wa] <= wd_runs;
    end
    rd_id   <= mem_id[scan_idx[dtj_pkg::SLOT_W-1:0]];
    rd_due  <= mem_due[scan_idx[dtj_pkg::SLOT_W-1:0]];
    rd_ival <= mem_ival[scan_idx[dtj_pkg::SLOT_W-1:0]];
    rd_rep  <= mem_rep[scan_idx[dtj_pkg::SLOT_W-1:0]];
    rd_runs <= mem_runs[scan_idx[dtj_pkg::SLOT_W-1:0]];
  end

  // Control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      next_id   <= dtj_pkg::ID_W'(1);
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
      scan_idx  <= '0;
      res_fire  <= 1'b0;
      found     <= 1'b0;
      hit       <= 1'b0;
      nfire     <= '0;
    end else begin
      if (emit_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      // Read issue shared by both scans
      if (state == S_RM_SCAN || state == S_TK_SCAN) begin
        if (scan_idx != dtj_pkg::CNT_W'(N)) begin
          rd_vld   <= 1'b1;
          rd_slot  <= scan_idx[dtj_pkg::SLOT_W-1:0];
          scan_idx <= scan_idx + 1'b1;
        end else begin
          rd_vld <= 1'b0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (take) begin
            target   <= target_id;
            now      <= now_time;
            scan_idx <= '0;
            rd_vld   <= 1'b0;
            res_due  <= '0;
            res_runs <= '0;
            res_last <= 1'b1;
            res_fire <= 1'b0;
            unique case (opcode) inside
              dtj_pkg::OP_ADD_REPEAT, dtj_pkg::OP_ADD_ONCE: begin
                state <= S_EMIT;
                if (free_any) begin
                  valid[free_slot] <= 1'b1;
                  next_id  <= id_inc;
                  res_kind <= dtj_pkg::K_ADDED;
                  res_id   <= next_id;
                  res_due  <= first_time;
                end else begin
                  res_kind <= dtj_pkg::K_FULL;
                  res_id   <= '0;
                end
              end
              dtj_pkg::OP_REMOVE: begin
                hit   <= 1'b0;
                state <= S_RM_SCAN;
              end
              default: begin
                found <= 1'b0;
                nfire <= '0;
                state <= S_TK_SCAN;
              end
            endcase
          end
        end

        S_RM_SCAN: begin
          if (rd_vld && valid[rd_slot] && rd_id == target) begin
            valid[rd_slot] <= 1'b0;
            hit <= 1'b1;
          end
          if (scan_end) begin
            res_kind <= hit ? dtj_pkg::K_REMOVED : dtj_pkg::K_NOTFOUND;
            res_id   <= hit ? target : '0;
            state    <= S_EMIT;
          end
        end

        S_TK_SCAN: begin
          if (rd_vld && valid[rd_slot] && rd_due <= now &&
              (!found || rd_due < best_due)) begin
            found     <= 1'b1;
            best_slot <= rd_slot;
            best_id   <= rd_id;
            best_due  <= rd_due;
            best_ival <= rd_ival;
            best_rep  <= rd_rep;
            best_runs <= rd_runs;
          end
          if (scan_end) begin
            state <= S_EMIT;
            if (found) begin
              res_kind <= dtj_pkg::K_FIRED;
              res_id   <= best_id;
              res_due  <= best_due;
              res_runs <= runs_inc;
              res_last <= 1'b0;
              res_fire <= 1'b1;
            end else begin
              res_kind <= dtj_pkg::K_DONE;
              res_id   <= '0;
              res_due  <= '0;
              res_runs <= '0;
              res_last <= 1'b1;
              res_fire <= 1'b0;
            end
          end
        end

        S_EMIT: begin
          if (out_free) begin
            kind      <= res_kind;
            job_id    <= res_id;
            due_time  <= res_due;
            run_count <= res_runs;
            last      <= res_last;
            if (res_fire) begin
              // one-shot job leaves the table once fired
              if (!best_rep) valid[best_slot] <= 1'b0;
              nfire <= nfire + 1'b1;
              found <= 1'b0;
              if (nfire + 1'b1 == dtj_pkg::FIRE_W'(dtj_pkg::MAX_FIRES)) begin
                res_kind <= dtj_pkg::K_DONE;
                res_id   <= '0;
                res_due  <= '0;
                res_runs <= '0;
                res_last <= 1'b1;
                res_fire <= 1'b0;
              end else begin
                scan_idx <= '0;
                rd_vld   <= 1'b0;
                state    <= S_TK_SCAN;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/dtj_checker.sv =====
// ----------------------------------------------------------------------------
// dtj_checker
// Port-level checks for the deadline timer job table.
// ----------------------------------------------------------------------------
module dtj_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [2:0]                 kind,
  input logic [dtj_pkg::ID_W-1:0]   job_id,
  input logic [dtj_pkg::RUNS_W-1:0] run_count,
  input logic                       last
);

  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == dtj_pkg::K_FIRED |-> !last && run_count != '0)
    else $error("fired item marked last or with zero run count");

  a_idless: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == dtj_pkg::K_FULL || kind == dtj_pkg::K_NOTFOUND ||
                  kind == dtj_pkg::K_DONE) |-> job_id == '0 && last)
    else $error("non-job item carries an id or is not last");

  a_added_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == dtj_pkg::K_ADDED |-> job_id != '0 && last)
    else $error("added item with id zero");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped before accept");

endmodule

bind deadline_timer_job_table dtj_checker u_dtj_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .job_id    (job_id),
  .run_count (run_count),
  .last      (last)
);
